// ----- design/srne_pkg.sv -----
`default_nettype none
package srne_pkg;
  localparam int MaxNeurons = 32;
  localparam int MaxFanin = 8;
  localparam int FracBits = 12;

  localparam logic [2:0] REQ_SYN = 3'd0;
  localparam logic [2:0] REQ_THR = 3'd1;
  localparam logic [2:0] REQ_OUT = 3'd2;
  localparam logic [2:0] REQ_PASS = 3'd3;
  localparam logic [2:0] REQ_REINF = 3'd4;
  localparam logic [2:0] REQ_PRUNE = 3'd5;

  localparam logic [2:0] CFG_ACTIVE = 3'd0;
  localparam logic [2:0] CFG_PRUNE = 3'd1;
  localparam logic [2:0] CFG_STRONG = 3'd2;
  localparam logic [2:0] CFG_WEAK = 3'd3;
  localparam logic [2:0] CFG_SLIM = 3'd4;
  localparam logic [2:0] CFG_FLIM = 3'd5;

  // round(65536 * tanh(k/8)), k = 0..32
  function automatic logic [16:0] tanh_lut(input logic [5:0] k);
    logic [16:0] r;
    unique case (k)
      6'd0: r = 17'd0;      6'd1: r = 17'd8150;   6'd2: r = 17'd16051;
      6'd3: r = 17'd23485;  6'd4: r = 17'd30285;  6'd5: r = 17'd36346;
      6'd6: r = 17'd41625;  6'd7: r = 17'd46131;  6'd8: r = 17'd49912;
      6'd9: r = 17'd53038;  6'd10: r = 17'd55592; 6'd11: r = 17'd57660;
      6'd12: r = 17'd59320; 6'd13: r = 17'd60643; 6'd14: r = 17'd61694;
      6'd15: r = 17'd62524; 6'd16: r = 17'd63178; 6'd17: r = 17'd63693;
      6'd18: r = 17'd64096; 6'd19: r = 17'd64412; 6'd20: r = 17'd64659;
      6'd21: r = 17'd64852; 6'd22: r = 17'd65003; 6'd23: r = 17'd65120;
      6'd24: r = 17'd65212; 6'd25: r = 17'd65283; 6'd26: r = 17'd65339;
      6'd27: r = 17'd65383; 6'd28: r = 17'd65417; 6'd29: r = 17'd65443;
      6'd30: r = 17'd65464; 6'd31: r = 17'd65480;
      default: r = 17'd65492;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- design/sparse_recurrent_neuron_engine_unit.sv -----
`default_nettype none
// Sparse recurrent neuron engine. Requests arrive on s_axis (tdata holds
// neuron_index, slot_index, source_neuron, data_value, slot_enable,
// success_flag from bit 0 up; tuser holds req_type). A run-pass request gives
// one transfer per active neuron on m_axis (tdata: result_neuron,
// result_output; tlast marks the final neuron). Synapses live in one memory
// of MAX_NEURONS*MAX_FANIN entries; neuron outputs in a second memory. For
// each active neuron a pass walks its slots through the two dependent memory
// reads (S_SRD, S_ORD) and the accumulate (S_MAC), then the activation and
// the output transfer, which waits for m_axis ready; a prune request sweeps
// the neuron's MAX_FANIN slots through S_SWEEP and S_SWB, and a reinforce
// request does the same after reading the streak word in S_ACT1; a write is
// accepted and then performed in the idle state. After reset a clearing pass
// clears the synapse valid bits and the neuron state before the first request.
module sparse_recurrent_neuron_engine_unit #(
  parameter int MAX_NEURONS = srne_pkg::MaxNeurons,
  parameter int MAX_FANIN = srne_pkg::MaxFanin,
  parameter int FRAC_BITS = srne_pkg::FracBits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // neuron_index[4:0], slot_index[7:5], source_neuron[12:8],
  // data_value[28:13], slot_enable[29], success_flag[30], zero[31]
  input  wire logic [31:0] s_axis_tdata,
  // req_type[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // result_neuron[4:0], result_output[20:5], zero[23:21]
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  import srne_pkg::*;

  localparam int NW = $clog2(MAX_NEURONS);
  localparam int FW = (MAX_FANIN > 1) ? $clog2(MAX_FANIN) : 1;
  localparam int DEPTH = MAX_NEURONS * MAX_FANIN;
  localparam int AW = $clog2(DEPTH);
  localparam int SH = FRAC_BITS - 2;
  localparam int ACCW = 32 + FW + 1;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_SRD   = 11'b00000000100,
    S_ORD   = 11'b00000001000,
    S_MAC   = 11'b00000010000,
    S_SUM   = 11'b00000100000,
    S_ACT1  = 11'b00001000000,
    S_ACT2  = 11'b00010000000,
    S_EMIT  = 11'b00100000000,
    S_SWEEP = 11'b01000000000,
    S_SWB   = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic [4:0]  src;
    logic [15:0] weight;
    logic        valid;
  } syn_t;

  state_t state;

  // configuration registers
  logic [5:0]  active_neurons;
  logic [14:0] prune_limit, strengthen_step, weaken_step;
  logic [3:0]  success_streak_limit, failure_streak_limit;

  // memories
  syn_t              syn_mem [DEPTH];
  logic [15:0]       out_mem [MAX_NEURONS];
  logic [15:0]       thr_mem [MAX_NEURONS];
  logic [7:0]        str_mem [MAX_NEURONS];
  syn_t              syn_q;
  logic [15:0]       out_q, thr_q;
  logic [7:0]        str_q;

  logic              syn_we, out_we;
  logic [AW-1:0]     syn_wa, syn_ra;
  syn_t              syn_wd;
  logic [NW-1:0]     out_wa, out_ra;
  logic [15:0]       out_wd;

  // held request
  logic [2:0]        req;
  logic [2:0]        rslot;
  logic [4:0]        rsrc;
  logic [15:0]       rdata;
  logic              ren, rok;

  logic [NW:0]       ncur;
  logic [NW:0]       count;
  logic [FW:0]       scnt;
  logic [AW:0]       clr;
  logic              wr_pend;
  logic              slot_live;
  logic signed [ACCW-1:0] acc;
  logic [15:0]       xq;
  logic              xneg;
  logic [16:0]       t0, t1;
  logic [SH-1:0]     fq;
  logic [16:0]       tval;
  logic              shift_pos;
  logic [14:0]       step_amt;
  logic              fire_q;

  logic [NW-1:0]     nidx;
  logic [FW-1:0]     sidx;
  logic [AW-1:0]     base;

  assign nidx = ncur[NW-1:0];
  assign sidx = scnt[FW-1:0];
  assign base = AW'(nidx) * AW'(MAX_FANIN);

  // streak update
  logic [3:0] ss_n, fs_n;
  logic       fire;
  always_comb begin
    ss_n = str_q[3:0];
    fs_n = str_q[7:4];
    fire = 1'b0;
    if (rok) begin
      fs_n = 4'd0;
      if (ss_n != 4'd15) ss_n = ss_n + 4'd1;
      if (ss_n >= success_streak_limit) begin
        fire = 1'b1;
        ss_n = 4'd0;
      end
    end else begin
      ss_n = 4'd0;
      if (fs_n != 4'd15) fs_n = fs_n + 4'd1;
      if (fs_n >= failure_streak_limit) begin
        fire = 1'b1;
        fs_n = 4'd0;
      end
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (syn_we) syn_mem[syn_wa] <= syn_wd;
    syn_q <= syn_mem[syn_ra];
    if (out_we) out_mem[out_wa] <= out_wd;
    out_q <= out_mem[out_ra];
    thr_q <= thr_mem[nidx];
    str_q <= str_mem[nidx];
    if (state == S_CLEAR) begin
      out_mem[clr[NW-1:0]] <= 16'd0;
      thr_mem[clr[NW-1:0]] <= 16'd0;
      str_mem[clr[NW-1:0]] <= 8'd0;
    end else if (state == S_IDLE && wr_pend && req == REQ_THR) begin
      thr_mem[nidx] <= rdata;
    end else if (state == S_SWEEP && req == REQ_REINF && scnt == '0) begin
      str_mem[nidx] <= {fs_n, ss_n};
    end
  end

  // weight shift and activation arithmetic
  logic signed [17:0] wsum;
  logic [15:0]        wsat;
  always_comb begin
    if (shift_pos) wsum = 18'(signed'(syn_q.weight)) + 18'(signed'({1'b0, step_amt}));
    else           wsum = 18'(signed'(syn_q.weight)) - 18'(signed'({1'b0, step_amt}));
    if (wsum > 18'sd32767) wsat = 16'h7fff;
    else if (wsum < -18'sd32768) wsat = 16'h8000;
    else wsat = wsum[15:0];
  end

  logic [15:0] wmag;
  assign wmag = syn_q.weight[15] ? 16'(-syn_q.weight) : syn_q.weight;

  logic signed [ACCW-1:0] fl;
  logic signed [ACCW-1:0] xd;
  logic [15:0]            xs;
  logic [15:0]            xmag;
  logic [16:0]            imax;
  always_comb begin
    fl = acc >>> FRAC_BITS;
    xd = fl - ACCW'(signed'(thr_q));
    if (xd > ACCW'(32767)) xs = 16'h7fff;
    else if (xd < -ACCW'(32768)) xs = 16'h8000;
    else xs = xd[15:0];
    xmag = xs[15] ? 16'(-xs) : xs;
    imax = 17'(xmag >> SH);
  end

  logic [16:0] tint;
  logic [16:0] rmag;
  logic [15:0] rout;
  always_comb begin
    tint = t0 + 17'((34'(t1 - t0) * 34'(fq)) >> SH);
    rmag = 17'((18'(tval) + 18'(1 << (15 - FRAC_BITS))) >> (16 - FRAC_BITS));
    rout = xneg ? 16'(-rmag) : rmag[15:0];
  end

  assign s_axis_tready = (state == S_IDLE) && !wr_pend;
  assign slot_live = syn_q.valid && ({1'b0, syn_q.src} < 6'(MAX_NEURONS));

  // memory port selection
  always_comb begin
    syn_we = 1'b0;
    syn_wa = base + AW'(rslot);
    syn_wd = '{src: rsrc, weight: rdata, valid: ren};
    syn_ra = base + AW'(sidx);
    out_we = 1'b0;
    out_wa = nidx;
    out_wd = rdata;
    out_ra = syn_q.src[NW-1:0];
    unique case (state)
      S_CLEAR: begin
        syn_we = 1'b1;
        syn_wa = clr[AW-1:0];
        syn_wd = '0;
      end
      S_IDLE: begin
        if (wr_pend && req == REQ_SYN) syn_we = 1'b1;
        if (wr_pend && req == REQ_OUT) out_we = 1'b1;
      end
      S_SRD: begin
        if (req == REQ_PASS && scnt == '0) begin
          out_we = 1'b1;
          out_wd = 16'd0;
        end
      end
      S_EMIT: begin
        out_we = m_axis_tvalid && m_axis_tready;
        out_wd = m_axis_tdata[20:5];
      end
      S_SWB: begin
        syn_ra = base + AW'(sidx);
        syn_wa = base + AW'(sidx);
        syn_wd = syn_q;
        if (req == REQ_REINF && syn_q.valid && fire_q) begin
          syn_we = 1'b1;
          syn_wd.weight = wsat;
        end
        if (req == REQ_PRUNE && syn_q.valid && wmag < {1'b0, prune_limit}) begin
          syn_we = 1'b1;
          syn_wd.valid = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      wr_pend <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tlast <= 1'b0;
      active_neurons <= 6'd20;
      prune_limit <= 15'd410;
      strengthen_step <= 15'd205;
      weaken_step <= 15'd205;
      success_streak_limit <= 4'd3;
      failure_streak_limit <= 4'd3;
      ncur <= '0;
      scnt <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ACTIVE: active_neurons <= cfg_data[5:0];
          CFG_PRUNE:  prune_limit <= cfg_data;
          CFG_STRONG: strengthen_step <= cfg_data;
          CFG_WEAK:   weaken_step <= cfg_data;
          CFG_SLIM:   success_streak_limit <= cfg_data[3:0];
          CFG_FLIM:   failure_streak_limit <= cfg_data[3:0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          ncur <= '0;
          if (clr == (AW+1)'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          wr_pend <= 1'b0;
          if (s_axis_tvalid && s_axis_tready) begin
            req <= s_axis_tuser;
            rslot <= s_axis_tdata[7:5];
            rsrc <= s_axis_tdata[12:8];
            rdata <= s_axis_tdata[28:13];
            ren <= s_axis_tdata[29];
            rok <= s_axis_tdata[30];
            scnt <= '0;
            acc <= '0;
            if (s_axis_tuser == REQ_PASS) begin
              ncur <= '0;
              count <= (active_neurons > 6'(MAX_NEURONS)) ? (NW+1)'(MAX_NEURONS)
                                                          : (NW+1)'(active_neurons);
              if (active_neurons != 6'd0) state <= S_SRD;
            end else if (6'(s_axis_tdata[4:0]) < 6'(MAX_NEURONS)) begin
              ncur <= (NW+1)'(s_axis_tdata[4:0]);
              if (s_axis_tuser == REQ_SYN) begin
                wr_pend <= (4'(s_axis_tdata[7:5]) < 4'(MAX_FANIN))
                        && (6'(s_axis_tdata[12:8]) < 6'(MAX_NEURONS));
              end else if (s_axis_tuser == REQ_THR || s_axis_tuser == REQ_OUT) begin
                wr_pend <= 1'b1;
              end else if (s_axis_tuser == REQ_REINF) begin
                state <= S_ACT1;
              end else if (s_axis_tuser == REQ_PRUNE) begin
                state <= S_SWEEP;
              end
            end
          end
        end
        S_SRD: state <= S_ORD;
        S_ORD: state <= S_MAC;
        S_MAC: begin
          if (slot_live) acc <= acc + ACCW'(signed'(out_q) * signed'(syn_q.weight));
          if (scnt == (FW+1)'(MAX_FANIN - 1)) state <= S_SUM;
          else begin
            scnt <= scnt + 1'b1;
            state <= S_SRD;
          end
        end
        S_SUM: begin
          xneg <= xs[15];
          if (imax >= 17'd32) begin
            t0 <= tanh_lut(6'd32);
            t1 <= tanh_lut(6'd32);
          end else begin
            t0 <= tanh_lut(imax[5:0]);
            t1 <= tanh_lut(imax[5:0] + 6'd1);
          end
          fq <= (imax >= 17'd32) ? '0 : xmag[SH-1:0];
          state <= S_ACT2;
        end
        S_ACT2: begin
          tval <= tint;
          state <= S_EMIT;
          m_axis_tvalid <= 1'b0;
        end
        S_ACT1: begin
          // reinforce: the streak word of the neuron is read in this cycle
          state <= S_SWEEP;
          scnt <= '0;
        end
        S_EMIT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {3'd0, rout, 5'(nidx)};
            m_axis_tlast <= (ncur + 1'b1) == count;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            acc <= '0;
            scnt <= '0;
            if ((ncur + 1'b1) == count) state <= S_IDLE;
            else begin
              ncur <= ncur + 1'b1;
              state <= S_SRD;
            end
          end
        end
        S_SWEEP: begin
          // Before the first slot, settle whether and how far the weights move.
          if (scnt == '0 && req == REQ_REINF) begin
            shift_pos <= rok;
            step_amt <= rok ? strengthen_step : weaken_step;
            fire_q <= fire;
          end
          state <= S_SWB;
        end
        S_SWB: begin
          state <= S_SWEEP;
          if (scnt == (FW+1)'(MAX_FANIN - 1)) state <= S_IDLE;
          else scnt <= scnt + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
